[rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants, codes and types of the tick task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int TAG_W      = 16;
    localparam int TIME_W     = 32;
    localparam int RC_W       = 8;
    localparam int RES_SLOT_W = 4;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_TABLE_FULL  = 3'd1,
        STAT_DEL_EMPTY   = 3'd2,
        STAT_QUEUE_EMPTY = 3'd3,
        STAT_STALE       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_TOO_MANY      = 2'd1,
        ERR_CANNOT_DELETE = 2'd2,
        ERR_RING_OVERFLOW = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_TICK,
        FSM_DISP_SLOT,
        FSM_DISP_WR
    } fsm_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [RC_W-1:0]   run_count;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_entry_t       data;
    } slot_wr_t;

    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] addr;
    } used_ctl_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SLOT_W-1:0] data;
    } ring_ctl_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [SLOT_W-1:0] head_q;
    } ring_stat_t;

endpackage

[rtl/tts_slot_table.sv]
// ----------------------------------------------------------------------------
// tts_slot_table
// Slot entry memory with registered read, plus per-slot used flags.
// ----------------------------------------------------------------------------
module tts_slot_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tts_pkg::SLOT_W-1:0]  rd_addr,
    input  tts_pkg::slot_wr_t           wr,
    input  tts_pkg::used_ctl_t          used_ctl,
    output tts_pkg::slot_entry_t        rd_q,
    output logic [tts_pkg::NUM_SLOTS-1:0] used
);

    tts_pkg::slot_entry_t mem [tts_pkg::NUM_SLOTS];
    logic [tts_pkg::NUM_SLOTS-1:0] used_reg;

    // entry memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_q <= mem[rd_addr];
    end

    // used flags, an unused slot reads as cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (used_ctl.set)
        begin
            used_reg[used_ctl.addr] <= 1'b1;
        end
        else if (used_ctl.clr)
        begin
            used_reg[used_ctl.addr] <= 1'b0;
        end
    end

    assign used = used_reg;

endmodule

[rtl/tts_ready_ring.sv]
// ----------------------------------------------------------------------------
// tts_ready_ring
// Ready ring of slot numbers with head and tail pointers.
// ----------------------------------------------------------------------------
module tts_ready_ring (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tts_pkg::ring_ctl_t   ctl,
    output tts_pkg::ring_stat_t  stat
);

    localparam logic [tts_pkg::SLOT_W-1:0] LAST = tts_pkg::SLOT_W'(tts_pkg::NUM_SLOTS - 1);

    logic [tts_pkg::SLOT_W-1:0] ring_mem [tts_pkg::NUM_SLOTS];
    logic [tts_pkg::SLOT_W-1:0] head_reg;
    logic [tts_pkg::SLOT_W-1:0] tail_reg;
    logic [tts_pkg::SLOT_W-1:0] head_inc;
    logic [tts_pkg::SLOT_W-1:0] tail_inc;
    logic [tts_pkg::SLOT_W-1:0] q_reg;

    // wrapping increments
    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;

    // ring storage, head entry read every cycle
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            ring_mem[tail_reg] <= ctl.data;
        end
        q_reg <= ring_mem[head_reg];
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            if (ctl.push)
            begin
                tail_reg <= tail_inc;
            end
            if (ctl.pop)
            begin
                head_reg <= head_inc;
            end
        end
    end

    assign stat.empty  = (head_reg == tail_reg);
    assign stat.full   = (tail_inc == head_reg);
    assign stat.head_q = q_reg;

endmodule

[rtl/tick_task_scheduler_ready_queue_core.sv]
// ----------------------------------------------------------------------------
// tick_task_scheduler_ready_queue_core
// Task slot scheduler with tick walk, add, delete and ready-ring dispatch.
// ----------------------------------------------------------------------------
// One beat in gives one result beat out. Add and delete finish in the cycle
// they are accepted. Dispatch runs as ring read, slot entry read, then update;
// on an empty ring it finishes in the cycle it is accepted. A tick walks the
// slot entry memory one entry per cycle behind its registered read, each used
// entry written back the cycle after it is read. A new command is taken once
// the previous one is done and the output register is free or being emptied.
module tick_task_scheduler_ready_queue_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_tag[15:0], first_delay[47:16], repeat_period[79:48], slot_select[83:80]
    input  logic [tts_pkg::IN_DATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_slot[3:0], result_tag[19:4], status[22:20], sticky_error[24:23]
    output logic [tts_pkg::OUT_DATA_W-1:0]  m_tdata
);

    tts_pkg::fsm_t state_reg, state_next;

    logic s_fire;
    tts_pkg::cmd_t cmd;
    logic [tts_pkg::TAG_W-1:0]  in_tag;
    logic [tts_pkg::TIME_W-1:0] in_delay;
    logic [tts_pkg::TIME_W-1:0] in_period;
    logic [3:0]                 in_sel;

    logic [tts_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [tts_pkg::SLOT_W-1:0] prev_reg;
    logic [tts_pkg::SLOT_W-1:0] disp_reg, disp_next;
    logic [1:0]                 err_reg, err_next;

    logic [tts_pkg::SLOT_W-1:0] rd_addr;
    tts_pkg::slot_entry_t       rd_q;
    tts_pkg::slot_entry_t       upd;
    tts_pkg::slot_wr_t          slot_wr;
    tts_pkg::used_ctl_t         used_ctl;
    logic [tts_pkg::NUM_SLOTS-1:0] used;
    tts_pkg::ring_ctl_t         ring_ctl;
    tts_pkg::ring_stat_t        ring_stat;

    logic                       free_found;
    logic [tts_pkg::SLOT_W-1:0] free_slot;
    logic                       sel_in_range;
    logic [tts_pkg::SLOT_W-1:0] sel_idx;
    logic                       tick_last;

    logic                        res_load;
    logic [tts_pkg::RES_SLOT_W-1:0] res_slot;
    logic [tts_pkg::TAG_W-1:0]   res_tag;
    logic [2:0]                  res_status;

    logic                        out_valid_reg;
    logic [tts_pkg::OUT_DATA_W-1:0] out_data_reg;

    // input unpacking
    assign cmd       = tts_pkg::cmd_t'(s_tuser);
    assign in_tag    = s_tdata[15:0];
    assign in_delay  = s_tdata[47:16];
    assign in_period = s_tdata[79:48];
    assign in_sel    = s_tdata[83:80];

    assign s_tready = (state_reg == tts_pkg::FSM_IDLE) && (!out_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    assign sel_in_range = (32'(in_sel) < tts_pkg::NUM_SLOTS);
    assign sel_idx      = tts_pkg::SLOT_W'(in_sel);
    assign tick_last    = (cnt_reg == tts_pkg::CNT_W'(tts_pkg::NUM_SLOTS));

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = tts_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                free_found = 1'b1;
                free_slot  = tts_pkg::SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tts_pkg::FSM_IDLE:
            begin
                if (s_fire && cmd == tts_pkg::CMD_TICK)
                begin
                    state_next = tts_pkg::FSM_TICK;
                end
                else if (s_fire && cmd == tts_pkg::CMD_DISPATCH && !ring_stat.empty)
                begin
                    state_next = tts_pkg::FSM_DISP_SLOT;
                end
            end
            tts_pkg::FSM_TICK:
            begin
                if (tick_last)
                begin
                    state_next = tts_pkg::FSM_IDLE;
                end
            end
            tts_pkg::FSM_DISP_SLOT:
            begin
                state_next = tts_pkg::FSM_DISP_WR;
            end
            tts_pkg::FSM_DISP_WR:
            begin
                state_next = tts_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = tts_pkg::FSM_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        slot_wr    = '0;
        used_ctl   = '0;
        ring_ctl   = '0;
        res_load   = 1'b0;
        res_slot   = '0;
        res_tag    = '0;
        res_status = tts_pkg::STAT_OK;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        disp_next  = disp_reg;
        rd_addr    = cnt_reg[tts_pkg::SLOT_W-1:0];
        upd        = rd_q;
        unique case (state_reg)
            tts_pkg::FSM_IDLE:
            begin
                if (s_fire)
                begin
                    case (cmd)
                        tts_pkg::CMD_TICK:
                        begin
                            cnt_next = '0;
                        end
                        tts_pkg::CMD_ADD:
                        begin
                            res_load = 1'b1;
                            if (free_found)
                            begin
                                used_ctl.set           = 1'b1;
                                used_ctl.addr          = free_slot;
                                slot_wr.en             = 1'b1;
                                slot_wr.addr           = free_slot;
                                slot_wr.data.tag       = in_tag;
                                slot_wr.data.delay     = in_delay;
                                slot_wr.data.period    = in_period;
                                slot_wr.data.run_count = '0;
                                res_slot = tts_pkg::RES_SLOT_W'(free_slot);
                            end
                            else
                            begin
                                err_next   = tts_pkg::ERR_TOO_MANY;
                                res_status = tts_pkg::STAT_TABLE_FULL;
                            end
                        end
                        tts_pkg::CMD_DELETE:
                        begin
                            res_load = 1'b1;
                            res_slot = in_sel;
                            if (!sel_in_range || !used[sel_idx])
                            begin
                                err_next   = tts_pkg::ERR_CANNOT_DELETE;
                                res_status = tts_pkg::STAT_DEL_EMPTY;
                            end
                            if (sel_in_range)
                            begin
                                used_ctl.clr  = 1'b1;
                                used_ctl.addr = sel_idx;
                            end
                        end
                        default:
                        begin
                            if (ring_stat.empty)
                            begin
                                res_load   = 1'b1;
                                res_status = tts_pkg::STAT_QUEUE_EMPTY;
                            end
                            else
                            begin
                                ring_ctl.pop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            tts_pkg::FSM_TICK:
            begin
                cnt_next = cnt_reg + 1'b1;
                // process the entry read in the previous cycle
                if (cnt_reg != '0 && used[prev_reg])
                begin
                    if (rd_q.delay == '0)
                    begin
                        if (ring_stat.full)
                        begin
                            err_next = tts_pkg::ERR_RING_OVERFLOW;
                        end
                        else
                        begin
                            if (rd_q.run_count != {tts_pkg::RC_W{1'b1}})
                            begin
                                upd.run_count = rd_q.run_count + 1'b1;
                            end
                            ring_ctl.push = 1'b1;
                            ring_ctl.data = prev_reg;
                        end
                        if (rd_q.period != '0)
                        begin
                            upd.delay = rd_q.period;
                        end
                    end
                    else
                    begin
                        upd.delay = rd_q.delay - 1'b1;
                    end
                    slot_wr.en   = 1'b1;
                    slot_wr.addr = prev_reg;
                    slot_wr.data = upd;
                end
                if (tick_last)
                begin
                    res_load = 1'b1;
                end
            end
            tts_pkg::FSM_DISP_SLOT:
            begin
                rd_addr   = ring_stat.head_q;
                disp_next = ring_stat.head_q;
            end
            tts_pkg::FSM_DISP_WR:
            begin
                res_load = 1'b1;
                res_slot = tts_pkg::RES_SLOT_W'(disp_reg);
                if (!used[disp_reg] || rd_q.run_count == '0)
                begin
                    res_status = tts_pkg::STAT_STALE;
                end
                else
                begin
                    res_tag       = rd_q.tag;
                    upd.run_count = rd_q.run_count - 1'b1;
                    slot_wr.en    = 1'b1;
                    slot_wr.addr  = disp_reg;
                    slot_wr.data  = upd;
                    if (rd_q.period == '0)
                    begin
                        used_ctl.clr  = 1'b1;
                        used_ctl.addr = disp_reg;
                    end
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tts_pkg::FSM_IDLE;
            err_reg       <= tts_pkg::ERR_NONE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prev_reg <= cnt_reg[tts_pkg::SLOT_W-1:0];
        disp_reg <= disp_next;
        if (res_load)
        begin
            out_data_reg <= {7'd0, err_next, res_status, res_tag, res_slot};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    tts_slot_table u_slot_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .wr       (slot_wr),
        .used_ctl (used_ctl),
        .rd_q     (rd_q),
        .used     (used)
    );

    tts_ready_ring u_ready_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .stat  (ring_stat)
    );

endmodule

[rtl/tts_checker.sv]
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [1:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tts_pkg::OUT_DATA_W-1:0]  m_tdata
);

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // result beat held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a tick walks the table, so no beat is taken right after it
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tuser == tts_pkg::CMD_TICK |=> !s_tready)
        else $error("beat accepted during tick walk");

    // add answers in the next cycle
    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tuser == tts_pkg::CMD_ADD |=> m_tvalid)
        else $error("add result missing");

    // table full reports the matching sticky error
    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[22:20] == tts_pkg::STAT_TABLE_FULL
            |-> m_tdata[24:23] == tts_pkg::ERR_TOO_MANY)
        else $error("table full without sticky error");

endmodule

bind tick_task_scheduler_ready_queue_core tts_checker u_tts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
